// ===== src/hand_raise_gesture_detector_top_assert.svh =====
// Assertion macros for the hand-raise gesture detector top level.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HAND_RAISE_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define HAND_RAISE_GESTURE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define HRGD_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("hrgd: implication failed");

// next-cycle implication, off while reset is asserted
`define HRGD_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("hrgd: next-cycle check failed");

`endif

// ===== src/hrgd_pkg.sv =====
// Package for the hand-raise gesture detector: phase and sequencer types,
// configuration register indexes and fixed arithmetic constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrgd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_COOL  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CHECK,
		SQ_MUL1,
		SQ_DIV1,
		SQ_SPD,
		SQ_MUL2,
		SQ_DIV2,
		SQ_FIN
	} seq_state_t;

	typedef enum logic [2:0] {
		CFG_ARM_BELOW = 3'd0,
		CFG_MIN_RISE  = 3'd1,
		CFG_MIN_SPEED = 3'd2,
		CFG_COOL_TIME = 3'd3,
		CFG_FULL_SPD  = 3'd4,
		CFG_STR_MIN   = 3'd5,
		CFG_STR_MAX   = 3'd6
	} cfg_idx_t;

	localparam logic [19:0]        MIN_TICK_US  = 20'd100;
	localparam logic signed [24:0] HEAD_OFFSET  = 25'sd40960;
	localparam logic [23:0]        ONE_CM_PER_S = 24'd256;
	localparam logic [23:0]        US_PER_S     = 24'd1000000;
	localparam logic [23:0]        HEIGHT_MAX   = 24'h7FFFFF;

	// last count of each division: speed quotient < 2^38, strength quotient < 2^16
	localparam logic [5:0] DIV1_LAST = 6'd37;
	localparam logic [5:0] DIV2_LAST = 6'd15;

endpackage

`default_nettype wire

// ===== src/hand_raise_gesture_detector_top.sv =====
// Hand-raise gesture detector for one hand, with its sequencer, shared
// multiplier and radix-2 divider. Depends on hrgd_pkg and the assertion header.
//
// Usage:
//  - Input channel (in_valid / in_stall) takes one tracked sample per tick.
//    in_stall is high whenever the sequencer is busy; one tick is worked at a time.
//  - Output channel (out_valid / out_stall) returns exactly one result per tick:
//    fired, strength, head_height_used and the phase after the tick.
//  - Path from acceptance to out_valid: ticks that need no speed go from check
//    straight to the final state; an armed tick adds the multiply and the
//    38-step speed division; a fire that needs strength interpolation adds a
//    second multiply and another 16-step division. The shared shift-subtract
//    divider gives one quotient bit per cycle. The next tick is accepted the
//    cycle after the result is loaded.
//  - The result sits in an output register; a stall on the output holds it and
//    the sequencer waits in its final state until the register frees up.
//  - Config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
//    write it only while no tick is in flight. Unknown indexes are dropped.
//  - Reset (arst_n low) clears the phase to idle, forgets the previous sample
//    and loads the register defaults (full-strength speed 1 cm/s, strength max
//    all ones).
`timescale 1ns / 1ps
`default_nettype none
`include "hand_raise_gesture_detector_top_assert.svh"

module hand_raise_gesture_detector_top (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               hand_valid,
	input  wire logic               trigger_held,
	input  wire logic               button_held,
	input  wire logic signed [23:0] hand_height,
	input  wire logic               head_valid,
	input  wire logic signed [23:0] head_height,
	input  wire logic [19:0]        tick_time,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    fired,
	output logic [15:0]             strength,
	output logic signed [23:0]      head_height_used,
	output logic [1:0]              phase
);

	// configuration registers
	logic [22:0] arm_below_q;
	logic [22:0] min_rise_q;
	logic [23:0] min_speed_q;
	logic [23:0] cool_time_q;
	logic [23:0] full_raw_q;
	logic [15:0] str_min_q;
	logic [15:0] str_max_q;

	// captured tick
	logic               hand_ok_q;
	logic               trig_q;
	logic               btn_q;
	logic signed [23:0] hand_q;
	logic               head_ok_q;
	logic signed [23:0] head_in_q;
	logic [19:0]        dt_q;

	// detector state
	hrgd_pkg::phase_t   phase_q;
	logic               have_prev_q;
	logic signed [23:0] prev_q;
	logic signed [23:0] lowest_q;
	logic signed [24:0] cool_left_q;

	// sequencer and shared datapath
	hrgd_pkg::seq_state_t seq_q, seq_d;
	logic [23:0] rem_q;
	logic [43:0] qr_q;
	logic [23:0] divisor_q;
	logic [5:0]  cnt_q;
	logic        spd_neg_q;
	logic        fire_q;
	logic [15:0] strength_q;
	logic        interp_q;

	// output register
	logic                    out_valid_q;
	logic                    fired_q;
	logic [15:0]             strength_out_q;
	logic signed [23:0]      head_used_q;
	hrgd_pkg::phase_t        phase_out_q;

	// control
	logic in_take;
	logic fin_go;
	logic need_speed;
	logic load_mul1;
	logic load_mul2;
	logic div_step;
	logic spd_load;
	logic chk_clear;

	// combinational datapath
	logic [23:0]        full_eff;
	logic signed [24:0] hand_sum;
	logic signed [23:0] head_sat;
	logic signed [23:0] head_used;
	logic signed [25:0] head_minus_arm;
	logic               low;
	logic signed [23:0] lowest_new;
	logic signed [24:0] rise;
	logic               rise_ok;
	logic signed [24:0] hdiff;
	logic signed [24:0] hdiff_neg;
	logic [23:0]        hdiff_mag;
	logic [37:0]        spd_mag;
	logic               spd_zero;
	logic               spd_pos;
	logic               speed_ok;
	logic               spd_full;
	logic               fire_c;
	logic [19:0]        dtf;
	logic signed [16:0] str_diff;
	logic signed [16:0] str_diff_neg;
	logic               str_neg;
	logic [15:0]        str_mag;
	logic [23:0]        mul_a;
	logic [23:0]        mul_b;
	logic [47:0]        prod;
	logic [24:0]        shifted;
	logic [25:0]        trial;
	logic               take;
	logic [15:0]        str_interp;
	logic [15:0]        str_final;
	logic signed [24:0] cool_next;
	logic               cool_done;

	// commit values
	hrgd_pkg::phase_t   phase_n;
	logic               have_prev_n;
	logic signed [23:0] prev_n;
	logic signed [23:0] lowest_n;
	logic signed [24:0] cool_left_n;

	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_below_q <= '0;
			min_rise_q  <= '0;
			min_speed_q <= '0;
			cool_time_q <= '0;
			full_raw_q  <= hrgd_pkg::ONE_CM_PER_S;
			str_min_q   <= '0;
			str_max_q   <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (hrgd_pkg::cfg_idx_t'(cfg_index))
				hrgd_pkg::CFG_ARM_BELOW: arm_below_q <= cfg_data[22:0];
				hrgd_pkg::CFG_MIN_RISE:  min_rise_q  <= cfg_data[22:0];
				hrgd_pkg::CFG_MIN_SPEED: min_speed_q <= cfg_data;
				hrgd_pkg::CFG_COOL_TIME: cool_time_q <= cfg_data;
				hrgd_pkg::CFG_FULL_SPD:  full_raw_q  <= cfg_data;
				hrgd_pkg::CFG_STR_MIN:   str_min_q   <= cfg_data[15:0];
				hrgd_pkg::CFG_STR_MAX:   str_max_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input capture
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_take) begin
			hand_ok_q <= hand_valid;
			trig_q    <= trigger_held;
			btn_q     <= button_held;
			hand_q    <= hand_height;
			head_ok_q <= head_valid;
			head_in_q <= head_height;
			dt_q      <= tick_time;
		end
	end

	// ------------------------------------------------------------------
	// Tick datapath
	// ------------------------------------------------------------------
	always_comb begin
		full_eff = (full_raw_q < hrgd_pkg::ONE_CM_PER_S) ? hrgd_pkg::ONE_CM_PER_S : full_raw_q;

		// missing head: hand plus 160 cm, saturated on the positive side
		hand_sum  = {hand_q[23], hand_q} + hrgd_pkg::HEAD_OFFSET;
		head_sat  = (!hand_sum[24] && hand_sum[23]) ? hrgd_pkg::HEIGHT_MAX : hand_sum[23:0];
		head_used = head_ok_q ? head_in_q : head_sat;

		head_minus_arm = {{2{head_used[23]}}, head_used} - {3'b000, arm_below_q};
		low = $signed({{2{hand_q[23]}}, hand_q}) <= head_minus_arm;

		lowest_new = (low && (hand_q < lowest_q)) ? hand_q : lowest_q;
		rise       = {hand_q[23], hand_q} - {lowest_new[23], lowest_new};
		rise_ok    = $signed({rise[24], rise}) >= $signed({3'b000, min_rise_q});

		hdiff     = {hand_q[23], hand_q} - {prev_q[23], prev_q};
		hdiff_neg = -hdiff;
		hdiff_mag = hdiff[24] ? hdiff_neg[23:0] : hdiff[23:0];

		// speed quotient lives in the divider shift register after the first division
		spd_mag  = qr_q[37:0];
		spd_zero = (spd_mag == '0);
		spd_pos  = !spd_neg_q && !spd_zero;
		speed_ok = !(spd_neg_q && !spd_zero) && (spd_mag >= {14'd0, min_speed_q});
		spd_full = spd_mag >= {14'd0, full_eff};
		fire_c   = rise_ok && speed_ok;

		dtf = (dt_q < hrgd_pkg::MIN_TICK_US) ? hrgd_pkg::MIN_TICK_US : dt_q;

		str_diff     = $signed({1'b0, str_max_q}) - $signed({1'b0, str_min_q});
		str_diff_neg = -str_diff;
		str_neg      = str_diff[16];
		str_mag      = str_neg ? str_diff_neg[15:0] : str_diff[15:0];

		cool_next = cool_left_q - $signed({5'd0, dt_q});
		cool_done = cool_next[24] || (cool_next == '0);
	end

	// shared multiplier
	always_comb begin
		if (seq_q == hrgd_pkg::SQ_MUL2) begin
			mul_a = {8'd0, str_mag};
			mul_b = spd_mag[23:0];
		end else begin
			mul_a = hdiff_mag;
			mul_b = hrgd_pkg::US_PER_S;
		end
		prod = mul_a * mul_b;
	end

	// shared divider step: one quotient bit a cycle
	always_comb begin
		shifted = {rem_q, qr_q[43]};
		trial   = {1'b0, shifted} - {2'b00, divisor_q};
		take    = !trial[25];
		// quotient rounds toward zero, so a negative slope subtracts the magnitude
		str_interp = str_neg ? (str_min_q - qr_q[15:0]) : (str_min_q + qr_q[15:0]);
		str_final  = interp_q ? str_interp : strength_q;
	end

	always_ff @(posedge clk) begin
		if (load_mul1) begin
			rem_q     <= {18'd0, prod[43:38]};
			qr_q      <= {prod[37:0], 6'd0};
			divisor_q <= {4'd0, dtf};
			spd_neg_q <= hdiff[24];
		end else if (load_mul2) begin
			rem_q     <= prod[39:16];
			qr_q      <= {prod[15:0], 28'd0};
			divisor_q <= full_eff;
		end else if (div_step) begin
			rem_q <= take ? trial[23:0] : shifted[23:0];
			qr_q  <= {qr_q[42:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			fire_q     <= 1'b0;
			strength_q <= '0;
			interp_q   <= 1'b0;
		end else begin
			if (load_mul1) begin
				cnt_q <= hrgd_pkg::DIV1_LAST;
			end else if (load_mul2) begin
				cnt_q <= hrgd_pkg::DIV2_LAST;
			end else if (div_step) begin
				cnt_q <= cnt_q - 6'd1;
			end

			if (chk_clear) begin
				fire_q     <= 1'b0;
				strength_q <= '0;
				interp_q   <= 1'b0;
			end else if (spd_load) begin
				fire_q     <= fire_c;
				strength_q <= !fire_c ? 16'd0 : (!spd_pos ? str_min_q :
				              (spd_full ? str_max_q : 16'd0));
				interp_q   <= fire_c && spd_pos && !spd_full;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		need_speed = hand_ok_q && trig_q && btn_q && have_prev_q &&
		             (phase_q == hrgd_pkg::PH_ARMED);
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			hrgd_pkg::SQ_IDLE:  if (in_valid) seq_d = hrgd_pkg::SQ_CHECK;
			hrgd_pkg::SQ_CHECK: seq_d = need_speed ? hrgd_pkg::SQ_MUL1 : hrgd_pkg::SQ_FIN;
			hrgd_pkg::SQ_MUL1:  seq_d = hrgd_pkg::SQ_DIV1;
			hrgd_pkg::SQ_DIV1:  if (cnt_q == '0) seq_d = hrgd_pkg::SQ_SPD;
			hrgd_pkg::SQ_SPD: begin
				seq_d = (fire_c && spd_pos && !spd_full) ? hrgd_pkg::SQ_MUL2 : hrgd_pkg::SQ_FIN;
			end
			hrgd_pkg::SQ_MUL2:  seq_d = hrgd_pkg::SQ_DIV2;
			hrgd_pkg::SQ_DIV2:  if (cnt_q == '0) seq_d = hrgd_pkg::SQ_FIN;
			hrgd_pkg::SQ_FIN:   if (!out_valid_q || !out_stall) seq_d = hrgd_pkg::SQ_IDLE;
			default:            seq_d = hrgd_pkg::SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		load_mul1 = 1'b0;
		load_mul2 = 1'b0;
		div_step  = 1'b0;
		spd_load  = 1'b0;
		chk_clear = 1'b0;
		fin_go    = 1'b0;
		case (seq_q)
			hrgd_pkg::SQ_IDLE:  in_stall  = 1'b0;
			hrgd_pkg::SQ_CHECK: chk_clear = 1'b1;
			hrgd_pkg::SQ_MUL1:  load_mul1 = 1'b1;
			hrgd_pkg::SQ_DIV1:  div_step  = 1'b1;
			hrgd_pkg::SQ_SPD:   spd_load  = 1'b1;
			hrgd_pkg::SQ_MUL2:  load_mul2 = 1'b1;
			hrgd_pkg::SQ_DIV2:  div_step  = 1'b1;
			hrgd_pkg::SQ_FIN:   fin_go    = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= hrgd_pkg::SQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	// ------------------------------------------------------------------
	// State commit
	// ------------------------------------------------------------------
	always_comb begin
		phase_n     = phase_q;
		have_prev_n = have_prev_q;
		prev_n      = prev_q;
		lowest_n    = lowest_q;
		cool_left_n = cool_left_q;
		if (!hand_ok_q) begin
			// untracked hand: hold everything
		end else if (!trig_q || !btn_q) begin
			phase_n     = hrgd_pkg::PH_IDLE;
			have_prev_n = 1'b0;
		end else if (phase_q == hrgd_pkg::PH_COOL) begin
			cool_left_n = cool_next;
			if (cool_done) phase_n = hrgd_pkg::PH_IDLE;
		end else if (!have_prev_q) begin
			prev_n      = hand_q;
			have_prev_n = 1'b1;
		end else begin
			case (phase_q)
				hrgd_pkg::PH_IDLE: begin
					if (low) begin
						phase_n  = hrgd_pkg::PH_ARMED;
						lowest_n = hand_q;
					end
				end
				hrgd_pkg::PH_ARMED: begin
					lowest_n = lowest_new;
					if (fire_q) begin
						phase_n     = hrgd_pkg::PH_COOL;
						cool_left_n = $signed({1'b0, cool_time_q});
					end
				end
				default: ;
			endcase
			prev_n = hand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrgd_pkg::PH_IDLE;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			lowest_q    <= '0;
			cool_left_q <= '0;
		end else if (fin_go) begin
			phase_q     <= phase_n;
			have_prev_q <= have_prev_n;
			prev_q      <= prev_n;
			lowest_q    <= lowest_n;
			cool_left_q <= cool_left_n;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			fired_q        <= fire_q;
			strength_out_q <= str_final;
			head_used_q    <= head_used;
			phase_out_q    <= phase_n;
		end
	end

	assign out_valid        = out_valid_q;
	assign fired            = fired_q;
	assign strength         = strength_out_q;
	assign head_height_used = head_used_q;
	assign phase            = phase_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`HRGD_ASSERT_IMPLY(a_fire_enters_cool, out_valid_q && fired_q,
		phase_out_q == hrgd_pkg::PH_COOL)
	`HRGD_ASSERT_IMPLY(a_no_fire_no_strength, out_valid_q && !fired_q, strength_out_q == 16'd0)
	`HRGD_ASSERT_NEXT(a_div1_ends, seq_q == hrgd_pkg::SQ_DIV1 && cnt_q == 6'd0,
		seq_q == hrgd_pkg::SQ_SPD)
	`HRGD_ASSERT_IMPLY(a_busy_stalls, seq_q != hrgd_pkg::SQ_IDLE, in_stall)

endmodule

`default_nettype wire
